// File: hw/rtl/bpd_pkg.sv
// Shared types, constants and register codes for the balance drive controller.
// Used by bpd_csr, bpd_ctrl, bpd_datapath and balance_pd_drive_controller.
`default_nettype none

package bpd_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int DT_BITS         = 8;
   localparam int OFFSET_BITS     = 10;
   localparam int GAIN_BITS       = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;

   localparam int MA_BITS   = 34;
   localparam int MB_BITS   = 18;
   localparam int PROD_BITS = MA_BITS + MB_BITS;

   localparam int STATE_BITS      = 32;
   localparam int DRIVE_BITS      = 10;
   localparam int COMPARE_BITS    = 16;
   localparam int TILT_WHOLE_BITS = 16;
   localparam int RSP_PAYLOAD_BITS = 2 * DRIVE_BITS + 2 * COMPARE_BITS + TILT_WHOLE_BITS + 1;
   localparam int RSP_BITS         = ((RSP_PAYLOAD_BITS + 7) / 8) * 8;

   localparam int ONE_Q16       = 65536;
   localparam int STATE_MAX     = 2147483647;
   localparam int STATE_MIN     = -2147483647 - 1;
   localparam int GYRO_DT_SCALE = 34360;
   localparam int BIAS_RECIP    = 1639;
   localparam int DRIVE_LIMIT   = 511 * ONE_Q16;
   localparam int REV_THRESHOLD = 466 * ONE_Q16;
   localparam int DB_HIGH       = 547;
   localparam int DB_LOW        = 477;
   localparam int WHEEL_MAX     = 1022;
   localparam int WHEEL_STOP    = 511;
   localparam int COMPARE_BASE  = 56523;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_LEAN_OFFSET  = 3'd0,
      REG_STEER_OFFSET = 3'd1,
      REG_RATE_OFFSET  = 3'd2,
      REG_PROP_GAIN    = 3'd3,
      REG_DERIV_GAIN   = 3'd4,
      REG_TURN_GAIN    = 3'd5,
      REG_BLEND_KEEP   = 3'd6
   } csr_reg_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] lean_offset;
      logic [OFFSET_BITS-1:0] steer_offset;
      logic [OFFSET_BITS-1:0] rate_offset;
      logic [GAIN_BITS-1:0]   prop_gain;
      logic [GAIN_BITS-1:0]   deriv_gain;
      logic [GAIN_BITS-1:0]   turn_gain;
      logic [GAIN_BITS-1:0]   blend_keep;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      lean_offset:  10'd512,
      steer_offset: 10'd512,
      rate_offset:  10'd522,
      prop_gain:    16'd102,
      deriv_gain:   16'd128,
      turn_gain:    16'd1024,
      blend_keep:   16'd63570
   };

   typedef enum logic [3:0] {
      OP_NONE,
      OP_BIAS,
      OP_GDT,
      OP_INC,
      OP_SUM,
      OP_KEEP,
      OP_LEAN,
      OP_TILT,
      OP_PROP,
      OP_DERIV,
      OP_DRIVE,
      OP_TURN,
      OP_WHEEL,
      OP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      logic      load;
      dp_op_type op;
   } dp_cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BIAS,
      ST_GDT,
      ST_INC,
      ST_SUM,
      ST_KEEP,
      ST_LEAN,
      ST_TILT,
      ST_PROP,
      ST_DERIV,
      ST_DRIVE,
      ST_TURN,
      ST_WHEEL,
      ST_FINISH
   } ctl_state_type;

   typedef struct packed {
      logic                               reverse_mode;
      logic signed [TILT_WHOLE_BITS-1:0]  tilt_whole;
      logic [COMPARE_BITS-1:0]            right_compare;
      logic [COMPARE_BITS-1:0]            left_compare;
      logic [DRIVE_BITS-1:0]              right_drive;
      logic [DRIVE_BITS-1:0]              left_drive;
   } result_type;

endpackage

`default_nettype wire

// File: hw/rtl/balance_pd_drive_controller.sv
// Balance drive controller top level: an accepted request transaction runs through
// twelve steps that share one 34x18 multiplier before its result is published, and
// no new request is taken until that result has been published.
// A request is taken while the previous result still waits in the output register.
// Synchronous active-high reset restores the register defaults, clears tilt and drive
// and selects forward mode. Depends on bpd_pkg, bpd_csr, bpd_ctrl and bpd_datapath.
`default_nettype none

module balance_pd_drive_controller import bpd_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   localparam int REQ_BITS = ((3 * SAMPLE_BITS + DT_BITS + 7) / 8) * 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // lean_sample, rate_sample, steer_sample, elapsed_ticks, zero fill
   input  wire logic [REQ_BITS-1:0]       req_tdata,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // left_drive, right_drive, left_compare, right_compare, tilt_whole,
   // reverse_mode, zero fill
   output logic [RSP_BITS-1:0]            rsp_tdata,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data
);

   cfg_type    cfg;
   dp_cmd_type cmd;
   result_type result;

   bpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bpd_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .cfg           (cfg),
      .lean_sample   (req_tdata[SAMPLE_BITS-1:0]),
      .rate_sample   (req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .steer_sample  (req_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
      .elapsed_ticks (req_tdata[3*SAMPLE_BITS+DT_BITS-1:3*SAMPLE_BITS]),
      .result        (result)
   );

   assign rsp_tdata = {(RSP_BITS - RSP_PAYLOAD_BITS)'(0), result};

endmodule

`default_nettype wire

// File: hw/rtl/bpd_csr.sv
// Configuration register file for the balance drive controller.
// Depends on bpd_pkg for the register codes, the config struct and reset values.
`default_nettype none

module bpd_csr import bpd_pkg::*; (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_data,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_reg_type'(csr_index))
            REG_LEAN_OFFSET:  cfg_in.lean_offset  = csr_data[OFFSET_BITS-1:0];
            REG_STEER_OFFSET: cfg_in.steer_offset = csr_data[OFFSET_BITS-1:0];
            REG_RATE_OFFSET:  cfg_in.rate_offset  = csr_data[OFFSET_BITS-1:0];
            REG_PROP_GAIN:    cfg_in.prop_gain    = csr_data[GAIN_BITS-1:0];
            REG_DERIV_GAIN:   cfg_in.deriv_gain   = csr_data[GAIN_BITS-1:0];
            REG_TURN_GAIN:    cfg_in.turn_gain    = csr_data[GAIN_BITS-1:0];
            REG_BLEND_KEEP:   cfg_in.blend_keep   = csr_data[GAIN_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/bpd_datapath.sv
// Datapath of the balance drive controller: sample scaling, one shared multiplier,
// filter and drive state, deadband logic and the result register. Depends on bpd_pkg.
`default_nettype none

module bpd_datapath import bpd_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   input  wire cfg_type                cfg,
   input  wire logic [SAMPLE_BITS-1:0] lean_sample,
   input  wire logic [SAMPLE_BITS-1:0] rate_sample,
   input  wire logic [SAMPLE_BITS-1:0] steer_sample,
   input  wire logic [DT_BITS-1:0]     elapsed_ticks,
   output result_type                  result
);

   localparam int OW         = (SAMPLE_BITS < OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS;
   localparam int DEG_BITS   = SAMPLE_BITS + 2;
   localparam int WHEEL_BITS = SAMPLE_BITS + 10;
   localparam int EXT_BITS   = SAMPLE_BITS + 6;

   localparam logic signed [PROD_BITS-1:0] SAT_HI = PROD_BITS'(STATE_MAX);
   localparam logic signed [PROD_BITS-1:0] SAT_LO = PROD_BITS'(STATE_MIN);
   localparam logic signed [PROD_BITS-1:0] DRV_HI = PROD_BITS'(DRIVE_LIMIT);
   localparam logic signed [PROD_BITS-1:0] DRV_LO = -PROD_BITS'(DRIVE_LIMIT);

   function automatic logic signed [DEG_BITS-1:0] scale14(
      input logic [SAMPLE_BITS-1:0] s,
      input logic [SAMPLE_BITS-1:0] o
   );
      logic signed [EXT_BITS-1:0] d;
      logic signed [EXT_BITS-1:0] m;
      d = signed'({6'b0, s}) - signed'({6'b0, o});
      m = (d <<< 4) - (d <<< 1);
      return DEG_BITS'(m >>> 5);
   endfunction

   function automatic logic signed [DEG_BITS-1:0] scale11(
      input logic [SAMPLE_BITS-1:0] s,
      input logic [SAMPLE_BITS-1:0] o
   );
      logic signed [EXT_BITS-1:0] d;
      logic signed [EXT_BITS-1:0] m;
      d = signed'({6'b0, s}) - signed'({6'b0, o});
      m = (d <<< 3) + (d <<< 1) + d;
      return DEG_BITS'(m >>> 5);
   endfunction

   function automatic logic signed [TILT_WHOLE_BITS-1:0] whole_part(
      input logic signed [STATE_BITS-1:0] v
   );
      logic signed [TILT_WHOLE_BITS-1:0] q;
      q = v[STATE_BITS-1:STATE_BITS-TILT_WHOLE_BITS];
      if (v[STATE_BITS-1] && (v[15:0] != 16'd0)) begin
         q = q + 16'sd1;
      end
      return q;
   endfunction

   logic signed [DEG_BITS-1:0]   lean_deg_ff, lean_deg_in;
   logic signed [DEG_BITS-1:0]   steer_deg_ff, steer_deg_in;
   logic signed [DEG_BITS-1:0]   gz_ff, gz_in;
   logic [DT_BITS-1:0]           dt_ff, dt_in;
   logic signed [PROD_BITS-1:0]  prod_ff, prod_in;
   logic signed [PROD_BITS-1:0]  acc_ff, acc_in;
   logic signed [STATE_BITS-1:0] tilt_ff, tilt_in;
   logic signed [STATE_BITS-1:0] base_drive_ff, base_drive_in;
   logic                         rev_ff, rev_in;
   logic signed [WHEEL_BITS-1:0] lm_ff, lm_in;
   logic signed [WHEEL_BITS-1:0] rm_ff, rm_in;
   result_type                   result_ff, result_in;

   logic signed [MA_BITS-1:0]          mul_a;
   logic signed [MB_BITS-1:0]          mul_b;
   logic [SAMPLE_BITS-1:0]             lean_off, steer_off, rate_off;
   logic [GAIN_BITS:0]                 keep_comp;
   logic signed [TILT_WHOLE_BITS-1:0]  drive_whole;
   logic [TILT_WHOLE_BITS-1:0]         drive_abs;
   logic [DRIVE_BITS-1:0]              drive_mag;
   logic signed [DEG_BITS-1:0]         bias_v;
   logic signed [PROD_BITS-1:0]        sum_v;
   logic signed [PROD_BITS-1:0]        turn_v;
   logic                               fwd_band;
   logic signed [WHEEL_BITS-1:0]       lm_db, rm_db;
   logic [DRIVE_BITS-1:0]              lm_cl, rm_cl;

   assign lean_off  = SAMPLE_BITS'(cfg.lean_offset[OW-1:0]);
   assign steer_off = SAMPLE_BITS'(cfg.steer_offset[OW-1:0]);
   assign rate_off  = SAMPLE_BITS'(cfg.rate_offset[OW-1:0]);
   assign keep_comp = (GAIN_BITS+1)'(ONE_Q16) - {1'b0, cfg.blend_keep};

   // Whole part of the drive fits in ten bits, so its magnitude fits the low bits.
   assign drive_whole = whole_part(base_drive_ff);
   assign drive_abs   = drive_whole[TILT_WHOLE_BITS-1] ? -drive_whole : drive_whole;
   assign drive_mag   = drive_abs[DRIVE_BITS-1:0];
   assign bias_v      = DEG_BITS'(prod_ff[21:16]);

   always_comb begin
      unique case (cmd.op)
         OP_BIAS: begin
            mul_a = MA_BITS'(drive_mag);
            mul_b = MB_BITS'(BIAS_RECIP);
         end
         OP_GDT: begin
            mul_a = MA_BITS'(gz_ff);
            mul_b = MB_BITS'(dt_ff);
         end
         OP_INC: begin
            mul_a = MA_BITS'(prod_ff);
            mul_b = MB_BITS'(GYRO_DT_SCALE);
         end
         OP_KEEP: begin
            mul_a = MA_BITS'(acc_ff);
            mul_b = MB_BITS'(cfg.blend_keep);
         end
         OP_LEAN: begin
            mul_a = MA_BITS'(lean_deg_ff);
            mul_b = MB_BITS'(keep_comp);
         end
         OP_PROP: begin
            mul_a = MA_BITS'(tilt_ff);
            mul_b = MB_BITS'(cfg.prop_gain);
         end
         OP_DERIV: begin
            mul_a = MA_BITS'(gz_ff);
            mul_b = MB_BITS'(cfg.deriv_gain);
         end
         OP_TURN: begin
            mul_a = MA_BITS'(steer_deg_ff);
            mul_b = MB_BITS'(cfg.turn_gain);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

   always_comb begin
      lean_deg_in   = lean_deg_ff;
      steer_deg_in  = steer_deg_ff;
      gz_in         = gz_ff;
      dt_in         = dt_ff;
      acc_in        = acc_ff;
      tilt_in       = tilt_ff;
      base_drive_in = base_drive_ff;
      rev_in        = rev_ff;
      lm_in         = lm_ff;
      rm_in         = rm_ff;
      result_in     = result_ff;
      sum_v         = '0;
      turn_v        = '0;
      fwd_band      = 1'b0;
      lm_db         = lm_ff;
      rm_db         = rm_ff;
      lm_cl         = '0;
      rm_cl         = '0;

      if (cmd.load) begin
         lean_deg_in  = scale14(lean_sample, lean_off);
         steer_deg_in = scale14(steer_sample, steer_off);
         gz_in        = scale11(rate_sample, rate_off);
         dt_in        = elapsed_ticks;
      end

      case (cmd.op)
         OP_GDT: begin
            lean_deg_in = base_drive_ff[STATE_BITS-1] ? lean_deg_ff - bias_v
                                                      : lean_deg_ff + bias_v;
         end
         OP_SUM: begin
            acc_in = PROD_BITS'(tilt_ff) + (prod_ff >>> 12);
         end
         OP_LEAN: begin
            acc_in = prod_ff >>> 16;
         end
         OP_TILT: begin
            sum_v = acc_ff + prod_ff;
            if (sum_v > SAT_HI) begin
               tilt_in = STATE_BITS'(STATE_MAX);
            end else if (sum_v < SAT_LO) begin
               tilt_in = STATE_BITS'(STATE_MIN);
            end else begin
               tilt_in = STATE_BITS'(sum_v);
            end
         end
         OP_DERIV: begin
            acc_in = PROD_BITS'(base_drive_ff) + (prod_ff >>> 8);
         end
         OP_DRIVE: begin
            sum_v = acc_ff + (prod_ff <<< 8);
            if (sum_v > DRV_HI) begin
               base_drive_in = STATE_BITS'(DRIVE_LIMIT);
            end else if (sum_v < DRV_LO) begin
               base_drive_in = -STATE_BITS'(DRIVE_LIMIT);
            end else begin
               base_drive_in = STATE_BITS'(sum_v);
            end
         end
         OP_WHEEL: begin
            turn_v = prod_ff >>> 8;
            if (prod_ff[PROD_BITS-1] && (prod_ff[7:0] != 8'd0)) begin
               turn_v = turn_v + PROD_BITS'(1);
            end
            lm_in = WHEEL_BITS'(WHEEL_STOP) + WHEEL_BITS'(drive_whole) + WHEEL_BITS'(turn_v);
            rm_in = WHEEL_BITS'(WHEEL_STOP) + WHEEL_BITS'(drive_whole) - WHEEL_BITS'(turn_v);
         end
         OP_PUBLISH: begin
            fwd_band = (lm_ff < DB_HIGH) && (lm_ff > DB_LOW) && !rev_ff;
            lm_db    = fwd_band ? WHEEL_BITS'(DB_HIGH) : lm_ff;
            rm_db    = (!fwd_band && (rm_ff < DB_HIGH) && (rm_ff > DB_LOW) && rev_ff)
                       ? WHEEL_BITS'(DB_LOW) : rm_ff;
            if (lm_db <= DB_HIGH) begin
               rev_in = 1'b0;
            end else if (base_drive_ff >= REV_THRESHOLD) begin
               rev_in = 1'b1;
            end
            if (lm_db < 0) begin
               lm_cl = '0;
            end else if (lm_db > WHEEL_MAX) begin
               lm_cl = DRIVE_BITS'(WHEEL_MAX);
            end else begin
               lm_cl = lm_db[DRIVE_BITS-1:0];
            end
            if (rm_db < 0) begin
               rm_cl = '0;
            end else if (rm_db > WHEEL_MAX) begin
               rm_cl = DRIVE_BITS'(WHEEL_MAX);
            end else begin
               rm_cl = rm_db[DRIVE_BITS-1:0];
            end
            result_in.left_drive    = lm_cl;
            result_in.right_drive   = rm_cl;
            result_in.left_compare  = COMPARE_BITS'(COMPARE_BASE) + COMPARE_BITS'(lm_cl);
            result_in.right_compare = COMPARE_BITS'(COMPARE_BASE) + COMPARE_BITS'(rm_cl);
            result_in.tilt_whole    = whole_part(tilt_ff);
            result_in.reverse_mode  = rev_in;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_ff       <= '0;
         base_drive_ff <= '0;
         rev_ff        <= 1'b0;
      end else begin
         tilt_ff       <= tilt_in;
         base_drive_ff <= base_drive_in;
         rev_ff        <= rev_in;
      end
   end

   always_ff @(posedge clock) begin
      lean_deg_ff  <= lean_deg_in;
      steer_deg_ff <= steer_deg_in;
      gz_ff        <= gz_in;
      dt_ff        <= dt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      lm_ff        <= lm_in;
      rm_ff        <= rm_in;
      result_ff    <= result_in;
   end

   assign result = result_ff;

   a_drive_in_range: assert property (@(posedge clock) disable iff (reset)
      (base_drive_ff <= DRIVE_LIMIT) && (base_drive_ff >= -DRIVE_LIMIT))
      else $error("drive state left its clamp range");

endmodule

`default_nettype wire

// File: hw/rtl/bpd_ctrl.sv
// Control sequencer of the balance drive controller: input and result handshakes
// and the step sequence for the shared multiplier. Depends on bpd_pkg.
`default_nettype none

module bpd_ctrl import bpd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   output dp_cmd_type cmd
);

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_BIAS;
            end
         end
         ST_BIAS:  begin cmd.op = OP_BIAS;  state_in = ST_GDT;   end
         ST_GDT:   begin cmd.op = OP_GDT;   state_in = ST_INC;   end
         ST_INC:   begin cmd.op = OP_INC;   state_in = ST_SUM;   end
         ST_SUM:   begin cmd.op = OP_SUM;   state_in = ST_KEEP;  end
         ST_KEEP:  begin cmd.op = OP_KEEP;  state_in = ST_LEAN;  end
         ST_LEAN:  begin cmd.op = OP_LEAN;  state_in = ST_TILT;  end
         ST_TILT:  begin cmd.op = OP_TILT;  state_in = ST_PROP;  end
         ST_PROP:  begin cmd.op = OP_PROP;  state_in = ST_DERIV; end
         ST_DERIV: begin cmd.op = OP_DERIV; state_in = ST_DRIVE; end
         ST_DRIVE: begin cmd.op = OP_DRIVE; state_in = ST_TURN;  end
         ST_TURN:  begin cmd.op = OP_TURN;  state_in = ST_WHEEL; end
         ST_WHEEL: begin cmd.op = OP_WHEEL; state_in = ST_FINISH; end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.op == OP_PUBLISH) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_BIAS) && !req_tready)
      else $error("accepted transaction did not start the sequence");

   a_finish_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == ST_FINISH) && rsp_valid_ff)
      else $error("pending result overwritten");

   a_valid_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside the finish step");

endmodule

`default_nettype wire
